FILE: rtl/tecm_pkg.sv
// Shared types, constants and state codes of the transitive edge color matrix.
`default_nettype none
package tecm_pkg;

  localparam int NODES   = 64;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int COLOR_W = 2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [1:0]         opcode_t;

  localparam opcode_t OP_SET  = 2'd0;
  localparam opcode_t OP_GET  = 2'd1;
  localparam opcode_t OP_LIST = 2'd2;

  localparam color_t COL_NONE   = 2'd0;
  localparam color_t COL_RED    = 2'd1;
  localparam color_t COL_GREEN  = 2'd2;
  localparam color_t COL_PURPLE = 2'd3;

  localparam cnt_t NODE_COUNT_RESET = 7'd64;
  localparam cnt_t NODES_CNT        = CNT_W'(NODES);

  // One matrix row: the colors of all edges of one node.
  typedef logic [NODES-1:0][COLOR_W-1:0] row_t;

  typedef struct packed {
    color_t color_out;
    idx_t   neighbor;
    logic   neighbor_valid;
    logic   responsive;
    cnt_t   found_count;
    logic   error;
    logic   last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } emit_t;

  typedef struct packed {
    logic en;
    idx_t row;
    row_t mask;
    row_t data;
  } ram_wr_t;

  typedef struct packed {
    logic en;
    idx_t row;
  } ram_rd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PW1, S_PW2, S_SETCHK, S_LDA, S_LDB, S_ILOOP, S_JLOOP,
    S_ALOOP, S_GET, S_LLOAD, S_LSCAN, S_LFIN, S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/tecm_if.sv
// Channel interfaces for commands, results and the configuration write.
`default_nettype none
interface tecm_cmd_if import tecm_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  idx_t    node_a;
  idx_t    node_b;
  color_t  color_in;
  cnt_t    max_neighbors;
  modport source (output valid, opcode, node_a, node_b, color_in, max_neighbors,
                  input ready);
  modport sink (input valid, opcode, node_a, node_b, color_in, max_neighbors,
                output ready);
endinterface

interface tecm_rsp_if import tecm_pkg::*; ();
  logic   valid;
  logic   ready;
  color_t color_out;
  idx_t   neighbor;
  logic   neighbor_valid;
  logic   responsive;
  cnt_t   found_count;
  logic   error;
  logic   last;
  modport source (output valid, color_out, neighbor, neighbor_valid, responsive,
                  found_count, error, last, input ready);
  modport sink (input valid, color_out, neighbor, neighbor_valid, responsive,
                found_count, error, last, output ready);
endinterface

interface tecm_cfg_if import tecm_pkg::*; ();
  logic valid;
  logic ready;
  cnt_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tecm_ram.sv
// Row-wide color memory with a per-bit write mask and registered read data.
`default_nettype none
module tecm_ram import tecm_pkg::*; (
  input  logic    clk,
  input  ram_wr_t wr,
  input  ram_rd_t rd,
  output row_t    rd_data
);

  row_t mem [NODES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= (mem[wr.row] & ~wr.mask) | (wr.data & wr.mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.row];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tecm_ctrl.sv
// Sequencer that runs get, neighbor list and set with red spreading over the row memory.
`default_nettype none
module tecm_ctrl import tecm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  opcode_t opcode,
  input  idx_t    node_a,
  input  idx_t    node_b,
  input  color_t  color_in,
  input  cnt_t    max_neighbors,
  input  cnt_t    node_count,
  output emit_t   emit,
  input  logic    emit_ready,
  output ram_wr_t wr,
  output ram_rd_t rd,
  input  row_t    rd_data
);

  state_t state, state_next, ret, ret_next;
  idx_t    a_q, a_q_next, b_q, b_q_next, px, px_next, py, py_next;
  idx_t    pend_idx, pend_idx_next;
  color_t  c_q, c_q_next;
  cnt_t    lim, lim_next, i_q, i_q_next, j_q, j_q_next, n_q, n_q_next;
  logic    resp, resp_next, pend, pend_next;
  row_t    row_a, row_a_next, row_b, row_b_next;
  result_t res, res_next;
  logic [NODES-1:0] row_valid, row_valid_next;
  logic    rd_vld, rd_vld_next;
  cnt_t    dim;
  row_t    rd_row;
  idx_t    wr_row, wr_col;
  logic    err;

  assign dim    = (node_count > NODES_CNT) ? NODES_CNT : node_count;
  assign rd_row = rd_vld ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
    end else begin
      state     <= state_next;
      row_valid <= row_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ret      <= ret_next;
    a_q      <= a_q_next;
    b_q      <= b_q_next;
    c_q      <= c_q_next;
    px       <= px_next;
    py       <= py_next;
    lim      <= lim_next;
    i_q      <= i_q_next;
    j_q      <= j_q_next;
    n_q      <= n_q_next;
    resp     <= resp_next;
    pend     <= pend_next;
    pend_idx <= pend_idx_next;
    row_a    <= row_a_next;
    row_b    <= row_b_next;
    res      <= res_next;
    rd_vld   <= rd_vld_next;
  end

  // Write port: one entry per cycle; a row never written before gets zeros elsewhere.
  always_comb begin
    wr_row = (state == S_PW2) ? py : px;
    wr_col = (state == S_PW2) ? px : py;
    wr.en  = (state == S_PW2) || ((state == S_PW1) && (px != py));
    wr.row = wr_row;
    for (int k = 0; k < NODES; k++) begin
      if (IDX_W'(k) == wr_col) begin
        wr.mask[k] = '1;
        wr.data[k] = c_q;
      end else begin
        wr.mask[k] = row_valid[wr_row] ? '0 : '1;
        wr.data[k] = COL_NONE;
      end
    end
  end

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    a_q_next       = a_q;
    b_q_next       = b_q;
    c_q_next       = c_q;
    px_next        = px;
    py_next        = py;
    lim_next       = lim;
    i_q_next       = i_q;
    j_q_next       = j_q;
    n_q_next       = n_q;
    resp_next      = resp;
    pend_next      = pend;
    pend_idx_next  = pend_idx;
    row_a_next     = row_a;
    row_b_next     = row_b;
    res_next       = res;
    row_valid_next = row_valid;
    rd_vld_next    = rd_vld;
    cmd_ready      = 1'b0;
    emit           = '0;
    rd             = '0;
    err            = 1'b0;

    if (wr.en) begin
      row_valid_next[wr_row] = 1'b1;
    end

    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        err = (opcode != OP_SET && opcode != OP_GET && opcode != OP_LIST) ||
              ({1'b0, node_a} >= dim) ||
              ((opcode != OP_LIST) && ({1'b0, node_b} >= dim));
        if (cmd_valid) begin
          a_q_next  = node_a;
          b_q_next  = node_b;
          c_q_next  = color_in;
          lim_next  = (max_neighbors > NODES_CNT) ? NODES_CNT : max_neighbors;
          res_next  = '0;
          res_next.last  = 1'b1;
          res_next.error = err;
          if (err) begin
            state_next = S_DONE;
          end else if (opcode == OP_SET) begin
            px_next    = node_a;
            py_next    = node_b;
            ret_next   = S_SETCHK;
            state_next = S_PW1;
          end else begin
            rd.en       = 1'b1;
            rd.row      = node_a;
            rd_vld_next = row_valid[node_a];
            state_next  = (opcode == OP_GET) ? S_GET : S_LLOAD;
          end
        end
      end
      S_PW1: begin
        if (px == py) begin
          state_next = ret;
        end else begin
          if (px == a_q) row_a_next[py] = c_q;
          if (py == a_q) row_a_next[px] = c_q;
          if (px == b_q) row_b_next[py] = c_q;
          if (py == b_q) row_b_next[px] = c_q;
          state_next = S_PW2;
        end
      end
      S_PW2: begin
        state_next = ret;
      end
      S_SETCHK: begin
        if (c_q == COL_PURPLE) begin
          state_next = S_DONE;
        end else begin
          rd.en       = 1'b1;
          rd.row      = a_q;
          rd_vld_next = row_valid[a_q];
          state_next  = S_LDA;
        end
      end
      S_LDA: begin
        row_a_next  = rd_row;
        rd.en       = 1'b1;
        rd.row      = b_q;
        rd_vld_next = row_valid[b_q];
        state_next  = S_LDB;
      end
      S_LDB: begin
        row_b_next = rd_row;
        i_q_next   = '0;
        state_next = S_ILOOP;
      end
      S_ILOOP: begin
        if (i_q == dim) begin
          j_q_next   = '0;
          state_next = S_ALOOP;
        end else if (row_a[i_q[IDX_W-1:0]] == COL_RED && i_q[IDX_W-1:0] != b_q) begin
          px_next    = i_q[IDX_W-1:0];
          py_next    = b_q;
          j_q_next   = '0;
          ret_next   = S_JLOOP;
          state_next = S_PW1;
        end else begin
          i_q_next = i_q + 1'b1;
        end
      end
      S_JLOOP: begin
        if (j_q == dim) begin
          i_q_next   = i_q + 1'b1;
          state_next = S_ILOOP;
        end else begin
          j_q_next = j_q + 1'b1;
          if (row_b[j_q[IDX_W-1:0]] == COL_RED && j_q[IDX_W-1:0] != a_q) begin
            px_next    = i_q[IDX_W-1:0];
            py_next    = j_q[IDX_W-1:0];
            ret_next   = S_JLOOP;
            state_next = S_PW1;
          end
        end
      end
      S_ALOOP: begin
        if (j_q == dim) begin
          state_next = S_DONE;
        end else begin
          j_q_next = j_q + 1'b1;
          if (row_b[j_q[IDX_W-1:0]] == COL_RED && j_q[IDX_W-1:0] != a_q) begin
            px_next    = a_q;
            py_next    = j_q[IDX_W-1:0];
            ret_next   = S_ALOOP;
            state_next = S_PW1;
          end
        end
      end
      S_GET: begin
        res_next.color_out = rd_row[b_q];
        state_next = S_DONE;
      end
      S_LLOAD: begin
        row_a_next = rd_row;
        i_q_next   = '0;
        n_q_next   = '0;
        resp_next  = 1'b0;
        pend_next  = 1'b0;
        state_next = S_LSCAN;
      end
      S_LSCAN: begin
        if (i_q == dim || n_q == lim) begin
          state_next = S_LFIN;
        end else if (row_a[i_q[IDX_W-1:0]] == COL_RED) begin
          // A found neighbor is held back until the next one shows it is not the last.
          emit.valid              = pend;
          emit.res.neighbor       = pend_idx;
          emit.res.neighbor_valid = 1'b1;
          if (!pend || emit_ready) begin
            pend_next     = 1'b1;
            pend_idx_next = i_q[IDX_W-1:0];
            n_q_next      = n_q + 1'b1;
            resp_next     = 1'b1;
            i_q_next      = i_q + 1'b1;
          end
        end else begin
          if (row_a[i_q[IDX_W-1:0]] == COL_GREEN) resp_next = 1'b1;
          i_q_next = i_q + 1'b1;
        end
      end
      S_LFIN: begin
        res_next                = '0;
        res_next.last           = 1'b1;
        res_next.responsive     = resp;
        res_next.found_count    = n_q;
        res_next.neighbor_valid = pend;
        res_next.neighbor       = pend ? pend_idx : '0;
        state_next = S_DONE;
      end
      S_DONE: begin
        emit.valid = 1'b1;
        emit.res   = res;
        if (emit_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/transitive_edge_color_matrix.sv
// Top level of the transitive edge color matrix: channels, node count register, result register.
//
// The block keeps a symmetric 64 x 64 matrix of 2-bit edge colors in a row-wide memory.
// Commands arrive on the cmd channel (set, get, list red neighbors); every command yields
// one or more result transactions on the rsp channel, the final one marked by last.
// The cfg channel writes node_count; it is always ready and is meant to be used only
// while the block is idle.
//
// Work is sequential: cmd.ready is high only while no command is in progress.
// A get reads row a and returns its entry for b. A list scans one matrix column per cycle
// over the dim columns, where dim is the effective node count, but stalls while a held
// neighbor waits on the output. A set runs the red spreading scan one column per cycle,
// pausing for each pair it writes through the single memory write port (one entry
// per cycle, two per painted edge).
//
// Reset clears the control state and marks every memory row as never written, so all
// edges read uncolored at once; no clearing pass runs. node_count returns to 64.
// Results sit in an output register; when rsp.ready is low the register holds its
// transaction and the sequencer waits before producing the next one.
`default_nettype none
module transitive_edge_color_matrix import tecm_pkg::*; (
  input logic clk,
  input logic rst,
  tecm_cmd_if.sink   cmd,
  tecm_rsp_if.source rsp,
  tecm_cfg_if.sink   cfg
);

  cnt_t    node_count;
  emit_t   emit;
  logic    emit_ready;
  ram_wr_t wr;
  ram_rd_t rd;
  row_t    rd_data;
  logic    out_valid;
  result_t out_res;

  // The node count register accepts a write every cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg.valid) begin
      node_count <= cfg.data;
    end
  end

  // The output register frees when its transaction is taken in the same cycle.
  assign emit_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ready) begin
      out_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit.valid) begin
      out_res <= emit.res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.color_out      = out_res.color_out;
  assign rsp.neighbor       = out_res.neighbor;
  assign rsp.neighbor_valid = out_res.neighbor_valid;
  assign rsp.responsive     = out_res.responsive;
  assign rsp.found_count    = out_res.found_count;
  assign rsp.error          = out_res.error;
  assign rsp.last           = out_res.last;

  tecm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .opcode        (cmd.opcode),
    .node_a        (cmd.node_a),
    .node_b        (cmd.node_b),
    .color_in      (cmd.color_in),
    .max_neighbors (cmd.max_neighbors),
    .node_count    (node_count),
    .emit          (emit),
    .emit_ready    (emit_ready),
    .wr            (wr),
    .rd            (rd),
    .rd_data       (rd_data)
  );

  tecm_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

FILE: rtl/tecm_checker.sv
// Port-level checker of the transitive edge color matrix and its bind.
`default_nettype none
module tecm_checker import tecm_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   rsp_valid,
  input logic   rsp_ready,
  input idx_t   neighbor,
  input logic   neighbor_valid,
  input logic   responsive,
  input cnt_t   found_count,
  input color_t color_out,
  input logic   error,
  input logic   last
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result transaction dropped while stalled");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error |-> last && !neighbor_valid && color_out == COL_NONE &&
                           found_count == '0 && !responsive)
    else $error("error result carries stray fields");

  a_nb_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !neighbor_valid |-> neighbor == '0)
    else $error("neighbor set without neighbor_valid");

  a_mid_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !last |-> neighbor_valid && found_count == '0 && !responsive)
    else $error("intermediate result carries summary fields");

endmodule

bind transitive_edge_color_matrix tecm_checker u_tecm_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .neighbor       (rsp.neighbor),
  .neighbor_valid (rsp.neighbor_valid),
  .responsive     (rsp.responsive),
  .found_count    (rsp.found_count),
  .color_out      (rsp.color_out),
  .error          (rsp.error),
  .last           (rsp.last)
);
`default_nettype wire

FILE: bench/transitive_edge_color_matrix_test.sv
// Testbench for the transitive edge color matrix: directed and random commands checked
// against a behavioral model of the edge matrix.
`timescale 1ns / 1ps
module transitive_edge_color_matrix_test;
  import tecm_pkg::*;

  localparam int STALL_LIMIT = 200000;  // cycles without any transaction
  localparam int SETTLE      = 40;      // cycles the sequencer may still run after a result

  logic clk;
  logic rst;

  tecm_cmd_if cmd ();
  tecm_rsp_if rsp ();
  tecm_cfg_if cfg ();

  transitive_edge_color_matrix i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp),
    .cfg (cfg)
  );

  // Model copy of the matrix and of the node count register.
  color_t  edge_mtx [NODES][NODES];
  int      node_cnt;
  result_t expected_results [$];

  int      send_idle_pct;
  int      rsp_stall_pct;
  int      errors;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Effective dimension: the register may hold more than the matrix has.
  function automatic int dim_now();
    return (node_cnt < NODES) ? node_cnt : NODES;
  endfunction

  // Writes both halves of a symmetric edge; the diagonal is never written.
  function automatic void paint_edge(int x, int y, color_t c);
    if (x != y) begin
      edge_mtx[x][y] = c;
      edge_mtx[y][x] = c;
    end
  endfunction

  function automatic result_t err_result();
    result_t r;
    r = '0;
    r.error = 1'b1;
    r.last  = 1'b1;
    return r;
  endfunction

  // Applies one command to the model and queues the results it should produce.
  function automatic void predict_edges(opcode_t op, idx_t a, idx_t b, color_t c, cnt_t lim);
    int      dim;
    int      found;
    int      limit;
    bit      seen;
    result_t r;
    dim = dim_now();
    r   = '0;
    if (op == OP_SET || op == OP_GET) begin
      if (a >= dim || b >= dim) begin
        expected_results.push_back(err_result());
        return;
      end
      if (op == OP_SET) begin
        paint_edge(a, b, c);
        // Every color but purple spreads across the red neighborhoods of a and b.
        // The scan reads the matrix as it is being rewritten, so order matters.
        if (c != COL_PURPLE) begin
          for (int i = 0; i < dim; i++) begin
            if (edge_mtx[a][i] == COL_RED && i != b) begin
              paint_edge(i, b, c);
              for (int j = 0; j < dim; j++)
                if (edge_mtx[b][j] == COL_RED && j != a) paint_edge(i, j, c);
            end
          end
          for (int j = 0; j < dim; j++)
            if (edge_mtx[b][j] == COL_RED && j != a) paint_edge(a, j, c);
        end
      end else begin
        r.color_out = edge_mtx[a][b];
      end
      r.last = 1'b1;
      expected_results.push_back(r);
    end else if (op == OP_LIST) begin
      if (a >= dim) begin
        expected_results.push_back(err_result());
        return;
      end
      limit = (lim > NODES) ? NODES : lim;
      found = 0;
      seen  = 1'b0;
      for (int i = 0; i < dim && found < limit; i++) begin
        if (edge_mtx[a][i] == COL_RED) begin
          r = '0;
          r.neighbor       = idx_t'(i);
          r.neighbor_valid = 1'b1;
          expected_results.push_back(r);
          found++;
          seen = 1'b1;
        end else if (edge_mtx[a][i] == COL_GREEN) begin
          seen = 1'b1;
        end
      end
      if (found == 0) begin
        r = '0;
        r.responsive = seen;
        r.last       = 1'b1;
        expected_results.push_back(r);
      end else begin
        // Summary fields ride on the final neighbor transaction.
        r = expected_results.pop_back();
        r.responsive  = seen;
        r.found_count = cnt_t'(found);
        r.last        = 1'b1;
        expected_results.push_back(r);
      end
    end else begin
      expected_results.push_back(err_result());
    end
  endfunction

  // Sends one command; valid stays high into the next call unless an idle cycle is drawn.
  task automatic send_cmd(opcode_t op, idx_t a, idx_t b, color_t c, cnt_t lim);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    predict_edges(op, a, b, c, lim);
    cmd.valid         <= 1'b1;
    cmd.opcode        <= op;
    cmd.node_a        <= a;
    cmd.node_b        <= b;
    cmd.color_in      <= c;
    cmd.max_neighbors <= lim;
    do @(posedge clk); while (!cmd.ready);
  endtask

  // Drops valid and waits until every queued result has come back.
  task automatic wait_drained();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Writes node_count once the block is idle.
  task automatic write_node_count(int value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= cnt_t'(value);
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    node_cnt = value & 127;
  endtask

  task automatic set_idling(int send_pct, int stall_pct);
    send_idle_pct = send_pct;
    rsp_stall_pct = stall_pct;
  endtask

  // One random command; mostly well-formed and within range, half of them sets, so that red chains build up.
  task automatic random_cmd();
    int      dim;
    opcode_t op;
    idx_t    a;
    idx_t    b;
    color_t  c;
    int      roll;
    dim  = dim_now();
    roll = $urandom_range(99);
    if (roll < 50)      op = OP_SET;
    else if (roll < 72) op = OP_GET;
    else if (roll < 95) op = OP_LIST;
    else                op = opcode_t'(3);
    if ($urandom_range(99) < 8) begin
      a = idx_t'($urandom_range(63));
      b = idx_t'($urandom_range(63));
    end else begin
      a = idx_t'($urandom_range(dim - 1));
      b = idx_t'($urandom_range(dim - 1));
    end
    // Red dominates so that the spreading has neighbors to work with.
    roll = $urandom_range(99);
    if (roll < 55)      c = COL_RED;
    else if (roll < 75) c = COL_GREEN;
    else if (roll < 88) c = COL_PURPLE;
    else                c = COL_NONE;
    send_cmd(op, a, b, c, cnt_t'($urandom_range(127)));
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    // Fresh matrix reads uncolored, including the diagonal and the far corner.
    send_cmd(OP_GET, 6'd0, 6'd63, COL_NONE, 7'd0);
    send_cmd(OP_GET, 6'd63, 6'd63, COL_NONE, 7'd0);
    send_cmd(OP_LIST, 6'd63, 6'd0, COL_NONE, 7'd64);
    // Build a red chain, then join two red neighborhoods so the color spreads.
    send_cmd(OP_SET, 6'd0, 6'd1, COL_RED, 7'd0);
    send_cmd(OP_SET, 6'd0, 6'd2, COL_RED, 7'd0);
    send_cmd(OP_SET, 6'd3, 6'd4, COL_RED, 7'd0);
    send_cmd(OP_SET, 6'd0, 6'd3, COL_RED, 7'd0);
    send_cmd(OP_LIST, 6'd0, 6'd0, COL_NONE, 7'd127);
    send_cmd(OP_LIST, 6'd4, 6'd0, COL_NONE, 7'd2);
    // A limit of zero scans nothing.
    send_cmd(OP_LIST, 6'd4, 6'd0, COL_NONE, 7'd0);
    // Purple does not spread; green does, and shows up as responsive with no reds.
    send_cmd(OP_SET, 6'd1, 6'd63, COL_PURPLE, 7'd0);
    send_cmd(OP_SET, 6'd10, 6'd11, COL_GREEN, 7'd0);
    send_cmd(OP_LIST, 6'd10, 6'd0, COL_NONE, 7'd5);
    // Set with a equal to b still runs the spreading; uncolored spreads as well.
    send_cmd(OP_SET, 6'd2, 6'd2, COL_GREEN, 7'd0);
    send_cmd(OP_SET, 6'd3, 6'd0, COL_NONE, 7'd0);
    send_cmd(OP_GET, 6'd1, 6'd2, COL_NONE, 7'd0);
    send_cmd(OP_GET, 6'd5, 6'd5, COL_NONE, 7'd0);
    // The unused opcode is rejected.
    send_cmd(opcode_t'(3), 6'd63, 6'd63, COL_PURPLE, 7'd127);
    wait_drained();
  endtask

  // Shrinking the count turns high indexes into errors but keeps the matrix.
  task automatic test_node_count();
    write_node_count(2);
    send_cmd(OP_SET, 6'd0, 6'd1, COL_RED, 7'd0);
    send_cmd(OP_SET, 6'd0, 6'd2, COL_RED, 7'd0);
    send_cmd(OP_LIST, 6'd1, 6'd0, COL_NONE, 7'd64);
    send_cmd(OP_LIST, 6'd2, 6'd0, COL_NONE, 7'd64);
    write_node_count(1);
    send_cmd(OP_SET, 6'd0, 6'd0, COL_RED, 7'd0);
    send_cmd(OP_GET, 6'd0, 6'd1, COL_NONE, 7'd0);
    send_cmd(OP_LIST, 6'd0, 6'd0, COL_NONE, 7'd1);
    write_node_count(64);
    send_cmd(OP_GET, 6'd0, 6'd3, COL_NONE, 7'd0);
    send_cmd(OP_LIST, 6'd3, 6'd0, COL_NONE, 7'd64);
    wait_drained();
  endtask

  // Random traffic in one idling phase; most items stay within the phase's node count.
  task automatic test_random_phase(int count, int nodes, int send_pct, int stall_pct);
    write_node_count(nodes);
    set_idling(send_pct, stall_pct);
    for (int n = 0; n < count; n++) begin
      random_cmd();
      // Let the pipe empty completely once in the middle of the phase.
      if (n == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst               = 1'b1;
    cmd.valid         = 1'b0;
    cmd.opcode        = OP_SET;
    cmd.node_a        = '0;
    cmd.node_b        = '0;
    cmd.color_in      = COL_NONE;
    cmd.max_neighbors = '0;
    cfg.valid         = 1'b0;
    cfg.data          = '0;
    errors            = 0;
    send_idle_pct     = 0;
    rsp_stall_pct     = 0;
    node_cnt          = NODE_COUNT_RESET;
    for (int x = 0; x < NODES; x++)
      for (int y = 0; y < NODES; y++) edge_mtx[x][y] = COL_NONE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_node_count();
    test_random_phase(110, 8, 0, 0);
    test_random_phase(100, 12, 78, 0);
    test_random_phase(100, 6, 0, 78);
    test_random_phase(80, 16, 12, 12);
    test_random_phase(30, 64, 0, 0);

    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result checker; it also draws the random back-pressure on the result channel.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (rsp.valid && rsp.ready) begin
        got.color_out      = rsp.color_out;
        got.neighbor       = rsp.neighbor;
        got.neighbor_valid = rsp.neighbor_valid;
        got.responsive     = rsp.responsive;
        got.found_count    = rsp.found_count;
        got.error          = rsp.error;
        got.last           = rsp.last;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction, actual %p", $realtime, got);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            errors++;
            $display("%0t: result mismatch, expected %p, actual %p", $realtime, want, got);
          end
        end
      end
    end
  end

  // The watchdog restarts on any transaction on any channel.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
